// File: rtl/core/stm_pkg.sv
// stm_pkg: types and codes of the send/receive tag matcher.
// Used by stm_scan, the top and the checker; depends on nothing.
package stm_pkg;

  localparam logic [1:0] KIND_SEND  = 2'd0;
  localparam logic [1:0] KIND_RECV  = 2'd1;
  localparam logic [1:0] KIND_FLUSH = 2'd2;
  // unused code, handled as a flush
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam logic [1:0] ST_STORED  = 2'd0;
  localparam logic [1:0] ST_MATCHED = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;
  localparam logic [1:0] ST_FLUSH   = 2'd3;

  localparam int CntW = 7;

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  rank;
    logic [9:0]  peer;
    logic [15:0] tag;
    logic [31:0] comm;
    logic [31:0] checksum;
    logic [31:0] byte_count;
    logic [15:0] type_id;
    logic [47:0] time_ticks;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      status;
    logic            integrity_bad;
    logic            type_bad;
    logic            size_bad;
    logic            latency_valid;
    logic [47:0]     latency;
    logic [CntW-1:0] pending_send_count;
    logic [CntW-1:0] pending_recv_count;
  } out_item_t;

  typedef struct packed {
    logic [9:0]  source;
    logic [9:0]  dest;
    logic [15:0] tag;
    logic [31:0] comm;
  } key_t;

  typedef struct packed {
    logic        is_recv;
    key_t        key;
    logic [31:0] checksum;
    logic [31:0] bytes;
    logic [15:0] type_id;
    logic [47:0] time_ticks;
    logic [31:0] order;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

endpackage

// File: rtl/core/stm_ram.sv
// stm_ram: generic single-port synchronous RAM, registered read.
// No dependencies.
module stm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// File: rtl/core/stm_scan.sv
// stm_scan: compares each entry read from the table with the probe key and
// keeps the oldest match and the lowest free slot. Depends on stm_pkg.
module stm_scan #(
  parameter int IW = 6
) (
  input  logic               clk,
  input  logic               clear,
  input  logic               rd_valid,
  input  logic [IW-1:0]      rd_idx,
  input  logic               rd_used,
  input  stm_pkg::entry_t    rd_data,
  input  stm_pkg::key_t      probe,
  input  logic               probe_recv,
  input  logic [31:0]        arrival,
  output logic               found,
  output logic [IW-1:0]      best_idx,
  output stm_pkg::entry_t    best,
  output logic               free_found,
  output logic [IW-1:0]      free_idx
);
  logic [31:0] best_age;
  logic [31:0] age;
  logic        hit;

  assign age = arrival - rd_data.order;
  assign hit = rd_valid && rd_used && (rd_data.is_recv != probe_recv) &&
               (rd_data.key == probe);

  always_ff @(posedge clk) begin
    if (clear) begin
      found      <= 1'b0;
      free_found <= 1'b0;
    end else begin
      if (hit && (!found || age > best_age)) begin
        found    <= 1'b1;
        best_idx <= rd_idx;
        best     <= rd_data;
        best_age <= age;
      end
      if (rd_valid && !rd_used && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= rd_idx;
      end
    end
  end
endmodule

// File: rtl/core/send_recv_tag_matcher_core.sv
// send_recv_tag_matcher_core: top level, sequencer, valid bits and counters.
// Depends on stm_pkg, stm_ram, stm_scan.
//
//  channel  | ports                 | handshake
//  ---------+-----------------------+------------------------------
//  item in  | start, busy, item     | taken when start && !busy
//  result   | done, result          | one-cycle strobe, no stall
//
// A flush is answered from the idle state without a scan; a send or receive
// scans every table entry, one table read per cycle through the single RAM port.
// Synchronous reset clears valid bits, counters and the sequencer.
// Results cannot be stalled; busy holds off new items during a scan.
module send_recv_tag_matcher_core #(
  parameter int ENTRIES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  stm_pkg::in_item_t    item,
  output logic                 done,
  output stm_pkg::out_item_t   result
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t               state;
  stm_pkg::in_item_t    cur;
  logic [ENTRIES-1:0]   valid;
  logic [CW-1:0]        n_send, n_recv;
  logic [31:0]          arrival;
  logic [IW:0]          cnt;
  logic                 rd_valid;
  logic [IW-1:0]        rd_idx;
  logic                 cur_recv;
  stm_pkg::key_t        probe;
  stm_pkg::entry_t      rd_data, best, wentry;
  logic                 found, free_found, clear, we;
  logic [IW-1:0]        best_idx, free_idx, addr;
  logic [47:0]          t_send, t_recv;

  assign busy     = (state != S_IDLE);
  assign cur_recv = (cur.kind == stm_pkg::KIND_RECV);
  assign probe.source = cur_recv ? cur.peer : cur.rank;
  assign probe.dest   = cur_recv ? cur.rank : cur.peer;
  assign probe.tag    = cur.tag;
  assign probe.comm   = cur.comm;
  assign clear = (state == S_IDLE);
  assign we    = (state == S_DONE) && !found && free_found;
  assign addr  = we ? free_idx : cnt[IW-1:0];

  assign wentry.is_recv    = cur_recv;
  assign wentry.key        = probe;
  assign wentry.checksum   = cur.checksum;
  assign wentry.bytes      = cur.byte_count;
  assign wentry.type_id    = cur.type_id;
  assign wentry.time_ticks = cur.time_ticks;
  assign wentry.order      = arrival;

  assign t_send = cur_recv ? best.time_ticks : cur.time_ticks;
  assign t_recv = cur_recv ? cur.time_ticks : best.time_ticks;

  stm_ram #(.WIDTH(stm_pkg::EntryW), .DEPTH(ENTRIES)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wentry), .rdata(rd_data)
  );

  stm_scan #(.IW(IW)) u_scan (
    .clk(clk), .clear(clear), .rd_valid(rd_valid), .rd_idx(rd_idx),
    .rd_used(valid[rd_idx]), .rd_data(rd_data), .probe(probe),
    .probe_recv(cur_recv), .arrival(arrival), .found(found),
    .best_idx(best_idx), .best(best), .free_found(free_found),
    .free_idx(free_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      valid    <= '0;
      n_send   <= '0;
      n_recv   <= '0;
      arrival  <= '0;
      done     <= 1'b0;
      rd_valid <= 1'b0;
      cnt      <= '0;
    end else begin
      done     <= 1'b0;
      rd_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cur <= item;
            cnt <= '0;
            if (item.kind != stm_pkg::KIND_SEND && item.kind != stm_pkg::KIND_RECV) begin
              result        <= '0;
              result.status <= stm_pkg::ST_FLUSH;
              result.pending_send_count <= (32'(n_send) > 32'd127) ? 7'd127 : 7'(n_send);
              result.pending_recv_count <= (32'(n_recv) > 32'd127) ? 7'd127 : 7'(n_recv);
              done    <= 1'b1;
              valid   <= '0;
              n_send  <= '0;
              n_recv  <= '0;
              arrival <= '0;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (cnt < (IW+1)'(ENTRIES)) begin
            rd_valid <= 1'b1;
            rd_idx   <= cnt[IW-1:0];
            cnt      <= cnt + 1'b1;
          end else if (!rd_valid) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          result <= '0;
          done   <= 1'b1;
          state  <= S_IDLE;
          if (found) begin
            result.status        <= stm_pkg::ST_MATCHED;
            result.integrity_bad <= (best.checksum != cur.checksum);
            result.type_bad      <= (best.type_id != cur.type_id);
            result.size_bad      <= (best.bytes != cur.byte_count);
            if (t_recv > t_send) begin
              result.latency_valid <= 1'b1;
              result.latency       <= t_recv - t_send;
            end
            valid[best_idx] <= 1'b0;
            if (best.is_recv) begin
              if (n_recv != '0) n_recv <= n_recv - 1'b1;
            end else begin
              if (n_send != '0) n_send <= n_send - 1'b1;
            end
          end else if (!free_found) begin
            result.status <= stm_pkg::ST_DROPPED;
          end else begin
            result.status   <= stm_pkg::ST_STORED;
            valid[free_idx] <= 1'b1;
            arrival         <= arrival + 32'd1;
            if (cur_recv) n_recv <= n_recv + 1'b1;
            else          n_send <= n_send + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/core/stm_checker.sv
// stm_checker: port-level assertions for the tag matcher, bound to the top.
// Depends on stm_pkg and send_recv_tag_matcher_core.
module stm_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input stm_pkg::in_item_t  item,
  input logic               done,
  input stm_pkg::out_item_t result
);
  logic take_flush, take_event;
  assign take_flush = start && !busy && item.kind != stm_pkg::KIND_SEND &&
                      item.kind != stm_pkg::KIND_RECV;
  assign take_event = start && !busy && (item.kind == stm_pkg::KIND_SEND ||
                      item.kind == stm_pkg::KIND_RECV);

  a_flush: assert property (@(posedge clk) disable iff (rst)
    take_flush |=> done && result.status == stm_pkg::ST_FLUSH)
    else $error("flush item gave no summary");

  a_event_busy: assert property (@(posedge clk) disable iff (rst)
    take_event |=> busy && !done)
    else $error("event item did not start a scan");

  a_counts: assert property (@(posedge clk) disable iff (rst)
    done && result.status != stm_pkg::ST_FLUSH |->
      result.pending_send_count == '0 && result.pending_recv_count == '0)
    else $error("counts outside flush");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    done && result.status != stm_pkg::ST_MATCHED |->
      !result.integrity_bad && !result.type_bad && !result.size_bad &&
      !result.latency_valid && result.latency == '0)
    else $error("match fields outside match");
endmodule

bind send_recv_tag_matcher_core stm_checker u_stm_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
  .done(done), .result(result)
);
